FILE: rtl/core/vrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_pkg
// shared types and constants for the vertex rotate / project pipeline
// ----------------------------------------------------------------------------
package vrp_pkg;

  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam int QUO_BITS   = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_COS_X  = 8'd0,
    REG_SIN_X  = 8'd1,
    REG_COS_Y  = 8'd2,
    REG_SIN_Y  = 8'd3,
    REG_DIST   = 8'd4,
    REG_SCALE  = 8'd5,
    REG_CEN_X  = 8'd6,
    REG_CEN_Y  = 8'd7
  } cfg_reg_t;

  localparam logic signed [15:0] RST_COS   = 16'sd16384;
  localparam logic signed [15:0] RST_SIN   = 16'sd0;
  localparam logic [14:0]        RST_DIST  = 15'd8192;
  localparam logic [9:0]         RST_SCALE = 10'd200;
  localparam logic [11:0]        RST_CEN_X = 12'd400;
  localparam logic [11:0]        RST_CEN_Y = 12'd300;

  localparam logic signed [15:0] SAT_POS       = 16'sh7fff;
  localparam logic signed [15:0] SAT_NEG       = 16'sh8000;
  localparam logic [QUO_BITS-1:0] POS_MAG_MAX  = 16'd32767;
  localparam logic [QUO_BITS-1:0] NEG_MAG_MAX  = 16'd32768;

  typedef struct packed {
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic signed [15:0] vertex_z;
  } vertex_t;

  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic               behind_camera;
    logic               clamped;
  } screen_t;

endpackage

FILE: rtl/core/vrp_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_stream_if
// valid / ready channel carrying one word per handshake
// ----------------------------------------------------------------------------
interface vrp_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/vertex_rotate_project_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_rotate_project_top
// rotates a Q3.12 vertex about X then Y, applies perspective d/(d+z) and
// pixel scale, and maps the result to saturated screen coordinates
// ----------------------------------------------------------------------------
// depth: 26 register stages from the input handshake to the output word
// throughput: one word per cycle unless the output stalls; 8 arithmetic stages
//   feed a 16-stage bit-per-stage divider plus overflow and saturation stages
// a stall at the output freezes the whole pipeline in place
// reset (synchronous, active high) clears all valid bits and loads the
//   default angle, distance, scale and center registers
module vertex_rotate_project_top #(
  parameter int COORD_FRAC_BITS = 12,
  parameter int TRIG_FRAC_BITS  = 14
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [vrp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [vrp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  vrp_stream_if.sink                      vertex,
  vrp_stream_if.source                    screen
);
  import vrp_pkg::*;

  localparam int C       = COORD_FRAC_BITS;
  localparam int T       = TRIG_FRAC_BITS;
  // first rotation: 16x16 products, sum of two, floor shift
  localparam int TY_W    = 33 - T;
  // second rotation sum width
  localparam int R_SUM_W = (TY_W + 17 > 33) ? TY_W + 17 : 33;
  localparam int RX_W    = R_SUM_W - T;
  // q = d + rz
  localparam int Q_W     = ((RX_W > 16) ? RX_W : 16) + 1;
  localparam int DEN_W   = Q_W - 1 + C;
  localparam int MX_W    = RX_W + 27;
  localparam int MY_W    = TY_W + 27;
  localparam int CQ_W    = Q_W + 13;
  localparam int N_W     = ((MX_W > CQ_W + C) ? MX_W : CQ_W + C) + 1;
  localparam int DIV_LAT = QUO_BITS + 2;
  localparam int LAT     = 8 + DIV_LAT;

  // configuration registers
  logic signed [15:0] cos_x, sin_x, cos_y, sin_y;
  logic [14:0]        view_dist;
  logic [9:0]         scale;
  logic [11:0]        cen_x, cen_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_x     <= RST_COS;
      sin_x     <= RST_SIN;
      cos_y     <= RST_COS;
      sin_y     <= RST_SIN;
      view_dist <= RST_DIST;
      scale     <= RST_SCALE;
      cen_x     <= RST_CEN_X;
      cen_y     <= RST_CEN_Y;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_COS_X: cos_x     <= $signed(cfg_wdata);
        REG_SIN_X: sin_x     <= $signed(cfg_wdata);
        REG_COS_Y: cos_y     <= $signed(cfg_wdata);
        REG_SIN_Y: sin_y     <= $signed(cfg_wdata);
        REG_DIST:  view_dist <= cfg_wdata[14:0];
        REG_SCALE: scale     <= cfg_wdata[9:0];
        REG_CEN_X: cen_x     <= cfg_wdata[11:0];
        REG_CEN_Y: cen_y     <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // pipeline advance: everything moves unless the output word is stalled
  logic           en;
  logic [LAT-1:0] vld;

  assign en           = !vld[LAT-1] || screen.ready;
  assign vertex.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], vertex.valid};
    end
  end

  // stage 1: first rotation products, x products for the second rotation
  logic signed [31:0] s1_ycx, s1_zsx, s1_ysx, s1_zcx, s1_xcy, s1_xsy;
  always_ff @(posedge clk) begin
    if (en) begin
      s1_ycx <= vertex.data.vertex_y * cos_x;
      s1_zsx <= vertex.data.vertex_z * sin_x;
      s1_ysx <= vertex.data.vertex_y * sin_x;
      s1_zcx <= vertex.data.vertex_z * cos_x;
      s1_xcy <= vertex.data.vertex_x * cos_y;
      s1_xsy <= vertex.data.vertex_x * sin_y;
    end
  end

  // stage 2: ty, tz with floor shift
  logic signed [32:0]     ty_sum, tz_sum;
  logic signed [TY_W-1:0] s2_ty, s2_tz;
  logic signed [31:0]     s2_xcy, s2_xsy;
  assign ty_sum = 33'(s1_ycx) - 33'(s1_zsx);
  assign tz_sum = 33'(s1_ysx) + 33'(s1_zcx);
  always_ff @(posedge clk) begin
    if (en) begin
      s2_ty  <= TY_W'(ty_sum >>> T);
      s2_tz  <= TY_W'(tz_sum >>> T);
      s2_xcy <= s1_xcy;
      s2_xsy <= s1_xsy;
    end
  end

  // stage 3: second rotation products on tz
  logic signed [TY_W+15:0] s3_tzsy, s3_tzcy;
  logic signed [TY_W-1:0]  s3_ty;
  logic signed [31:0]      s3_xcy, s3_xsy;
  always_ff @(posedge clk) begin
    if (en) begin
      s3_tzsy <= s2_tz * sin_y;
      s3_tzcy <= s2_tz * cos_y;
      s3_ty   <= s2_ty;
      s3_xcy  <= s2_xcy;
      s3_xsy  <= s2_xsy;
    end
  end

  // stage 4: rx, rz
  logic signed [R_SUM_W-1:0] rx_sum, rz_sum;
  logic signed [RX_W-1:0]    s4_rx, s4_rz;
  logic signed [TY_W-1:0]    s4_ty;
  assign rx_sum = R_SUM_W'(s3_xcy) + R_SUM_W'(s3_tzsy);
  assign rz_sum = R_SUM_W'(s3_tzcy) - R_SUM_W'(s3_xsy);
  always_ff @(posedge clk) begin
    if (en) begin
      s4_rx <= RX_W'(rx_sum >>> T);
      s4_rz <= RX_W'(rz_sum >>> T);
      s4_ty <= s3_ty;
    end
  end

  // stage 5: q = d + rz, numerators times d
  logic signed [Q_W-1:0]     s5_q;
  logic signed [RX_W+15:0]   s5_rxd;
  logic signed [TY_W+15:0]   s5_tyd;
  always_ff @(posedge clk) begin
    if (en) begin
      s5_q   <= Q_W'(s4_rz) + Q_W'($signed({1'b0, view_dist}));
      s5_rxd <= s4_rx * $signed({1'b0, view_dist});
      s5_tyd <= s4_ty * $signed({1'b0, view_dist});
    end
  end

  // stage 6: times pixel scale, center times q, camera test
  logic signed [MX_W-1:0] s6_mx;
  logic signed [MY_W-1:0] s6_my;
  logic signed [CQ_W-1:0] s6_cxq, s6_cyq;
  logic signed [Q_W-1:0]  s6_q;
  logic                   s6_beh;
  always_ff @(posedge clk) begin
    if (en) begin
      s6_mx  <= s5_rxd * $signed({1'b0, scale});
      s6_my  <= s5_tyd * $signed({1'b0, scale});
      s6_cxq <= s5_q * $signed({1'b0, cen_x});
      s6_cyq <= s5_q * $signed({1'b0, cen_y});
      s6_q   <= s5_q;
      s6_beh <= s5_q <= 0;
    end
  end

  // stage 7: full numerators, denominator q * 2^C (y is negated)
  logic signed [N_W-1:0] s7_nx, s7_ny;
  logic [DEN_W-1:0]      s7_den;
  logic                  s7_beh;
  always_ff @(posedge clk) begin
    if (en) begin
      s7_nx  <= N_W'(s6_mx) + (N_W'(s6_cxq) <<< C);
      s7_ny  <= (N_W'(s6_cyq) <<< C) - N_W'(s6_my);
      s7_den <= {s6_q[Q_W-2:0], {C{1'b0}}};
      s7_beh <= s6_beh;
    end
  end

  // stage 8: sign and magnitude for truncation toward zero
  logic [N_W-1:0]   s8_mag_x, s8_mag_y;
  logic             s8_neg_x, s8_neg_y;
  logic [DEN_W-1:0] s8_den;
  logic             s8_beh;
  always_ff @(posedge clk) begin
    if (en) begin
      s8_neg_x <= s7_nx[N_W-1];
      s8_neg_y <= s7_ny[N_W-1];
      s8_mag_x <= s7_nx[N_W-1] ? N_W'(-s7_nx) : N_W'(s7_nx);
      s8_mag_y <= s7_ny[N_W-1] ? N_W'(-s7_ny) : N_W'(s7_ny);
      s8_den   <= s7_den;
      s8_beh   <= s7_beh;
    end
  end

  // dividers, one per coordinate
  logic signed [15:0] div_x, div_y;
  logic               clamp_x, clamp_y;

  vrp_div #(.NUM_W(N_W), .DEN_W(DEN_W)) u_div_x (
    .clk     (clk),
    .en      (en),
    .num_mag (s8_mag_x),
    .den     (s8_den),
    .neg     (s8_neg_x),
    .value   (div_x),
    .clamped (clamp_x)
  );

  vrp_div #(.NUM_W(N_W), .DEN_W(DEN_W)) u_div_y (
    .clk     (clk),
    .en      (en),
    .num_mag (s8_mag_y),
    .den     (s8_den),
    .neg     (s8_neg_y),
    .value   (div_y),
    .clamped (clamp_y)
  );

  // behind-camera flag rides alongside the divider
  logic [DIV_LAT-1:0] beh_line;
  always_ff @(posedge clk) begin
    if (en) begin
      beh_line <= {beh_line[DIV_LAT-2:0], s8_beh};
    end
  end

  // output word
  logic out_beh;
  assign out_beh                    = beh_line[DIV_LAT-1];
  assign screen.valid               = vld[LAT-1];
  assign screen.data.screen_x       = out_beh ? 16'sd0 : div_x;
  assign screen.data.screen_y       = out_beh ? 16'sd0 : div_y;
  assign screen.data.behind_camera  = out_beh;
  assign screen.data.clamped        = !out_beh && (clamp_x || clamp_y);

  // checks
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid bits moved while stalled");

  a_behind_zero: assert property (@(posedge clk) disable iff (rst)
    (screen.valid && screen.data.behind_camera) |->
      (screen.data.screen_x == 16'sd0 && screen.data.screen_y == 16'sd0 &&
       !screen.data.clamped))
    else $error("behind-camera word carries coordinates");

  a_clamp_bound: assert property (@(posedge clk) disable iff (rst)
    (screen.valid && screen.data.clamped) |->
      (screen.data.screen_x == SAT_POS || screen.data.screen_x == SAT_NEG ||
       screen.data.screen_y == SAT_POS || screen.data.screen_y == SAT_NEG))
    else $error("clamped word not at a bound");

endmodule

FILE: rtl/core/vrp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_div
// pipelined restoring divider, one quotient bit per stage, saturating result
// ----------------------------------------------------------------------------
module vrp_div #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 35
) (
  input  logic                clk,
  input  logic                en,
  input  logic [NUM_W-1:0]    num_mag,
  input  logic [DEN_W-1:0]    den,
  input  logic                neg,
  output logic signed [15:0]  value,
  output logic                clamped
);
  import vrp_pkg::*;

  localparam int W = (NUM_W > DEN_W + QUO_BITS + 1) ? NUM_W : DEN_W + QUO_BITS + 1;

  logic [W-1:0]        rem   [0:QUO_BITS];
  logic [DEN_W-1:0]    den_r [0:QUO_BITS];
  logic [QUO_BITS-1:0] quo   [0:QUO_BITS];
  logic                neg_r [0:QUO_BITS];
  logic                ovf_r [0:QUO_BITS];

  // overflow check: quotient would need more than QUO_BITS bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]   <= W'(num_mag);
      den_r[0] <= den;
      quo[0]   <= '0;
      neg_r[0] <= neg;
      ovf_r[0] <= W'(num_mag) >= (W'(den) << QUO_BITS);
    end
  end

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_bit
    logic [W-1:0] shifted;
    logic         ge;
    assign shifted = W'(den_r[k]) << (QUO_BITS - 1 - k);
    assign ge      = rem[k] >= shifted;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]   <= ge ? rem[k] - shifted : rem[k];
        quo[k+1]   <= {quo[k][QUO_BITS-2:0], ge};
        den_r[k+1] <= den_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_r[QUO_BITS]) begin
        if (ovf_r[QUO_BITS] || quo[QUO_BITS] > NEG_MAG_MAX) begin
          value   <= SAT_NEG;
          clamped <= 1'b1;
        end else begin
          value   <= -$signed(quo[QUO_BITS]);
          clamped <= 1'b0;
        end
      end else begin
        if (ovf_r[QUO_BITS] || quo[QUO_BITS] > POS_MAG_MAX) begin
          value   <= SAT_POS;
          clamped <= 1'b1;
        end else begin
          value   <= $signed(quo[QUO_BITS]);
          clamped <= 1'b0;
        end
      end
    end
  end

endmodule
